// File: rtl/markup_token_lexer_unit_assert.svh
// ----------------------------------------------------------------------------
// markup token lexer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef MARKUP_TOKEN_LEXER_UNIT_ASSERT_SVH
`define MARKUP_TOKEN_LEXER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MTL_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("markup token lexer check failed");

// next-cycle implication, disabled in reset
`define MTL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("markup token lexer check failed");

`endif

// File: rtl/mtl_pkg.sv
// ----------------------------------------------------------------------------
// mtl_pkg
// shared types and constants of the markup token lexer
// ----------------------------------------------------------------------------
`default_nettype none

package mtl_pkg;

	localparam int POS_WIDTH_DEF = 16;
	localparam int POS_OUT_W     = 16;
	localparam int QUEUE_DEPTH   = 4;

	typedef enum logic [2:0] {
		TK_UNKNOWN = 3'd0,
		TK_START   = 3'd1,
		TK_SLASH   = 3'd2,
		TK_CLOSE   = 3'd3,
		TK_NAME    = 3'd4,
		TK_EQUAL   = 3'd5,
		TK_VALUE   = 3'd6
	} token_kind_t;

	// one queue entry: the one or two results caused by a byte
	typedef struct packed {
		logic                 two;
		token_kind_t          kind_a;
		token_kind_t          kind_b;
		logic                 err;
		logic [POS_OUT_W-1:0] line;
		logic [POS_OUT_W-1:0] col;
	} rec_t;

endpackage

`default_nettype wire

// File: rtl/mtl_front.sv
// ----------------------------------------------------------------------------
// mtl_front
// byte classifier, lexer mode machine and line and column counters
// ----------------------------------------------------------------------------
`default_nettype none

module mtl_front #(
	parameter int POS_WIDTH = mtl_pkg::POS_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   char_in,
	input  wire logic         q_full,
	output logic              push,
	output mtl_pkg::rec_t     push_rec
);

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_NAME  = 2'd1,
		MODE_QUOTE = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		CL_UNKNOWN, CL_OPEN, CL_CLOSE, CL_SLASH, CL_QUOTE,
		CL_EQUAL, CL_NEWLINE, CL_SPACE, CL_DIGIT, CL_LETTER
	} class_t;

	localparam logic [7:0] CH_LT  = 8'h3C;
	localparam logic [7:0] CH_GT  = 8'h3E;
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_SL  = 8'h2F;
	localparam logic [7:0] CH_QT  = 8'h22;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_US  = 8'h5F;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_D0  = 8'h30;
	localparam logic [7:0] CH_D9  = 8'h39;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LZ  = 8'h7A;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UZ  = 8'h5A;

	localparam logic [POS_WIDTH-1:0] PosMax = '1;
	localparam int ExtW = (POS_WIDTH > mtl_pkg::POS_OUT_W) ? POS_WIDTH : mtl_pkg::POS_OUT_W;

	mode_t                  mode_q, mode_d;
	logic                   halted_q;
	logic [POS_WIDTH-1:0]   line_q, line_d;
	logic [POS_WIDTH-1:0]   col_q, col_d;
	logic [ExtW-1:0]        line_ext, col_ext;
	class_t                 cls;
	logic                   take;
	logic                   emit_f, emit_d, dispatch, err_d;
	mtl_pkg::token_kind_t   kind_f, kind_d;

	always_comb begin
		case (char_in) inside
			CH_LT:                  cls = CL_OPEN;
			CH_GT:                  cls = CL_CLOSE;
			CH_EQ:                  cls = CL_EQUAL;
			CH_SL:                  cls = CL_SLASH;
			CH_QT:                  cls = CL_QUOTE;
			CH_NL:                  cls = CL_NEWLINE;
			CH_SP, CH_TAB, CH_CR:   cls = CL_SPACE;
			[CH_D0:CH_D9]:          cls = CL_DIGIT;
			[CH_LA:CH_LZ], [CH_UA:CH_UZ], CH_US, CH_DOT: cls = CL_LETTER;
			default:                cls = CL_UNKNOWN;
		endcase
	end

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready && !halted_q;

	// mode machine: a flushed run comes first, then the byte, unless it closed a value, is handled from idle
	always_comb begin
		mode_d   = mode_q;
		emit_f   = 1'b0;
		kind_f   = mtl_pkg::TK_UNKNOWN;
		dispatch = 1'b0;
		emit_d   = 1'b0;
		kind_d   = mtl_pkg::TK_UNKNOWN;
		err_d    = 1'b0;
		if (cls != CL_NEWLINE && cls != CL_SPACE) begin
			case (mode_q)
				MODE_NAME: begin
					if (cls != CL_LETTER) begin
						emit_f   = 1'b1;
						kind_f   = mtl_pkg::TK_NAME;
						mode_d   = MODE_IDLE;
						dispatch = 1'b1;
					end
				end
				MODE_QUOTE: begin
					if (cls == CL_QUOTE) begin
						emit_f = 1'b1;
						kind_f = mtl_pkg::TK_VALUE;
						mode_d = MODE_IDLE;
					end else if (cls != CL_LETTER && cls != CL_DIGIT) begin
						emit_f   = 1'b1;
						kind_f   = mtl_pkg::TK_UNKNOWN;
						mode_d   = MODE_IDLE;
						dispatch = 1'b1;
					end
				end
				default: begin
					mode_d   = MODE_IDLE;
					dispatch = 1'b1;
				end
			endcase
			if (dispatch) begin
				case (cls)
					CL_OPEN: begin
						emit_d = 1'b1;
						kind_d = mtl_pkg::TK_START;
					end
					CL_SLASH: begin
						emit_d = 1'b1;
						kind_d = mtl_pkg::TK_SLASH;
					end
					CL_CLOSE: begin
						emit_d = 1'b1;
						kind_d = mtl_pkg::TK_CLOSE;
					end
					CL_EQUAL: begin
						emit_d = 1'b1;
						kind_d = mtl_pkg::TK_EQUAL;
					end
					CL_LETTER: mode_d = MODE_NAME;
					CL_QUOTE:  mode_d = MODE_QUOTE;
					default: begin
						emit_d = 1'b1;
						err_d  = 1'b1;
					end
				endcase
			end
		end
	end

	// saturating counters; a newline restarts the column
	always_comb begin
		line_d = line_q;
		col_d  = (col_q != PosMax) ? col_q + POS_WIDTH'(1) : col_q;
		if (cls == CL_NEWLINE) begin
			col_d = '0;
			if (line_q != PosMax) line_d = line_q + POS_WIDTH'(1);
		end
	end

	assign line_ext = ExtW'(line_d);
	assign col_ext  = ExtW'(col_d);

	assign push            = take && (emit_f || emit_d);
	assign push_rec.two    = emit_f && emit_d;
	assign push_rec.kind_a = emit_f ? kind_f : kind_d;
	assign push_rec.kind_b = kind_d;
	assign push_rec.err    = err_d;
	assign push_rec.line   = line_ext[mtl_pkg::POS_OUT_W-1:0];
	assign push_rec.col    = col_ext[mtl_pkg::POS_OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (take) begin
			mode_q <= mode_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
			line_q   <= '0;
			col_q    <= '0;
		end else if (take) begin
			halted_q <= err_d;
			line_q   <= line_d;
			col_q    <= col_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/mtl_queue.sv
// ----------------------------------------------------------------------------
// mtl_queue
// short first-in first-out queue between the lexer front and the output side
// ----------------------------------------------------------------------------
`default_nettype none

module mtl_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire mtl_pkg::rec_t push_rec,
	output logic               full,
	input  wire logic          pop,
	output mtl_pkg::rec_t      head_rec,
	output logic               empty
);

	localparam int Depth = mtl_pkg::QUEUE_DEPTH;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	mtl_pkg::rec_t   entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign full     = (count_q == CntW'(Depth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_rec = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/mtl_back.sv
// ----------------------------------------------------------------------------
// mtl_back
// output register: splits a queue entry into one or two result items
// ----------------------------------------------------------------------------
`default_nettype none

module mtl_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  wire mtl_pkg::rec_t head_rec,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output mtl_pkg::token_kind_t token_kind,
	output logic               error,
	output logic [mtl_pkg::POS_OUT_W-1:0] line_no,
	output logic [mtl_pkg::POS_OUT_W-1:0] column_no,
	output logic               last_of_run
);

	mtl_pkg::rec_t rec_q;
	logic          valid_q;
	logic          phase_q;
	logic          advance;
	logic          second_due;

	assign advance    = !valid_q || out_ready;
	// the second item of a two-item entry still has to go out
	assign second_due = valid_q && rec_q.two && !phase_q;
	assign pop        = advance && !second_due && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (advance) begin
			if (second_due) begin
				phase_q <= 1'b1;
			end else begin
				valid_q <= !q_empty;
				phase_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) rec_q <= head_rec;
	end

	assign out_valid   = valid_q;
	assign last_of_run = !rec_q.two || phase_q;
	assign token_kind  = phase_q ? rec_q.kind_b : rec_q.kind_a;
	assign error       = rec_q.err && last_of_run;
	assign line_no     = rec_q.line;
	assign column_no   = rec_q.col;

endmodule

`default_nettype wire

// File: rtl/markup_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// markup_token_lexer_unit
// tag markup tokenizer: one text byte in, zero to two token items out
// ----------------------------------------------------------------------------
// input channel s_*: one byte per item in s_tdata[7:0]; taken at one byte per
//   cycle while the result queue has room
// output channel m_*: token items; m_tuser holds kind and error flag, m_tdata
//   holds line and column of the causing byte, m_tlast marks its final item
// a tokenising byte is written into the queue when it is accepted, and is loaded
//   into the output register, which then presents its first item, once free
// bytes are taken at one byte per cycle while the queue has room; a byte with
//   two items (a flushed name or cut-off value then a symbol or error item)
//   uses the single output register, one item a cycle while m_tready is high
// the queue holds four entries behind the output register, so a stalled
//   receiver backs up into s_tready after five tokenising bytes; whitespace and
//   newlines pass without entries only while the queue has room
// an illegal byte gives one error item, then every later byte is taken and
//   dropped until reset
// reset: mode idle, counters zero, queue and output register empty
// ----------------------------------------------------------------------------
`default_nettype none

module markup_token_lexer_unit #(
	parameter int POS_WIDTH = mtl_pkg::POS_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_in
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [15:0] line_no, [31:16] column_no
	output logic [3:0]       m_tuser,   // [2:0] token_kind, [3] error
	output logic             m_tlast    // last_of_run
);

	logic                 q_full, q_empty, push, pop;
	mtl_pkg::rec_t        push_rec, head_rec;
	mtl_pkg::token_kind_t token_kind;
	logic                 error;
	logic [mtl_pkg::POS_OUT_W-1:0] line_no, column_no;

	mtl_front #(
		.POS_WIDTH (POS_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.char_in  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_rec (push_rec)
	);

	mtl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (pop),
		.head_rec (head_rec),
		.empty    (q_empty)
	);

	mtl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head_rec    (head_rec),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.token_kind  (token_kind),
		.error       (error),
		.line_no     (line_no),
		.column_no   (column_no),
		.last_of_run (m_tlast)
	);

	assign m_tdata = {column_no, line_no};
	assign m_tuser = {error, token_kind};

endmodule

`default_nettype wire

// File: rtl/mtl_checker.sv
// ----------------------------------------------------------------------------
// mtl_checker
// port-level checks of the markup token lexer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "markup_token_lexer_unit_assert.svh"

module mtl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [7:0]  s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [3:0]  m_tuser,
	input wire logic        m_tlast
);

	// an error item closes the run of its byte
	`MTL_ASSERT_SAME(a_err_last, m_tvalid && m_tuser[3], m_tlast)
	// an error item carries kind unknown
	`MTL_ASSERT_SAME(a_err_kind, m_tvalid && m_tuser[3], m_tuser[2:0] == mtl_pkg::TK_UNKNOWN)
	// nothing follows the error item
	`MTL_ASSERT_NEXT(a_err_final, m_tvalid && m_tready && m_tuser[3], !m_tvalid)
	// a stalled item holds
	`MTL_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	// an offered byte stays put until taken
	`MTL_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata))

endmodule

bind markup_token_lexer_unit mtl_checker u_mtl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

// File: tb/mtl_token_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtl_token_checker
// follows the lexer from the accepted bytes and checks every token item that
// leaves the block against the tokens worked out from those bytes
// ----------------------------------------------------------------------------

module mtl_token_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_in
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,   // [15:0] line_no, [31:16] column_no
	input  wire logic [3:0]  m_tuser,   // [2:0] token_kind, [3] error
	input  wire logic        m_tlast,
	input  wire logic        run_done,
	output int               pending,
	output int               fail_count,
	output int               token_count
);

	localparam logic [mtl_pkg::POS_OUT_W-1:0] POS_TOP = '1;
	localparam int PRINT_CAP = 100;

	typedef enum logic [1:0] {
		LX_IDLE  = 2'd0,
		LX_NAME  = 2'd1,
		LX_QUOTE = 2'd2
	} lex_mode_t;

	typedef enum logic [3:0] {
		CC_UNKNOWN,
		CC_OPEN,
		CC_CLOSE,
		CC_SLASH,
		CC_QUOTE,
		CC_EQUAL,
		CC_NEWLINE,
		CC_SPACE,
		CC_DIGIT,
		CC_LETTER
	} char_class_t;

	typedef struct packed {
		mtl_pkg::token_kind_t          kind;
		logic                          err;
		logic [mtl_pkg::POS_OUT_W-1:0] line;
		logic [mtl_pkg::POS_OUT_W-1:0] col;
		logic                          last;
	} token_rec_t;

	token_rec_t                    due_tokens[$];
	token_rec_t                    want;
	lex_mode_t                     lex_mode;
	logic [mtl_pkg::POS_OUT_W-1:0] line_cnt;
	logic [mtl_pkg::POS_OUT_W-1:0] col_cnt;
	logic                          halted;
	logic                          leftovers_done;
	int                            n_fail = 0;
	int                            n_tokens = 0;

	assign fail_count  = n_fail;
	assign token_count = n_tokens;

	task automatic report_mismatch(input string what);
		if (n_fail < PRINT_CAP) begin
			$display("[%0t] token mismatch: %s", $time, what);
		end
		n_fail++;
	endtask

	function automatic char_class_t classify(input logic [7:0] b);
		if (b == "<") return CC_OPEN;
		if (b == ">") return CC_CLOSE;
		if (b == "=") return CC_EQUAL;
		if (b == "/") return CC_SLASH;
		if (b == "\"") return CC_QUOTE;
		if (b == "\n") return CC_NEWLINE;
		if (b == " " || b == "\t" || b == "\r") return CC_SPACE;
		if (b == "_" || b == ".") return CC_LETTER;
		if (b >= "0" && b <= "9") return CC_DIGIT;
		if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) return CC_LETTER;
		return CC_UNKNOWN;
	endfunction

	// advances the lexer by one byte and queues the tokens it gives
	task automatic lex_byte(input logic [7:0] b);
		char_class_t          cls;
		token_rec_t           rec;
		mtl_pkg::token_kind_t flush_kind;
		mtl_pkg::token_kind_t sym_kind;
		logic                 has_flush;
		logic                 has_sym;
		logic                 sym_err;
		logic                 settled;
		has_flush  = 1'b0;
		has_sym    = 1'b0;
		sym_err    = 1'b0;
		settled    = 1'b0;
		flush_kind = mtl_pkg::TK_UNKNOWN;
		sym_kind   = mtl_pkg::TK_UNKNOWN;
		if (halted) return;
		if (col_cnt != POS_TOP) col_cnt++;
		cls = classify(b);
		if (cls == CC_NEWLINE) begin
			if (line_cnt != POS_TOP) line_cnt++;
			col_cnt = '0;
			return;
		end
		// blanks leave the mode alone, even mid-name or mid-value
		if (cls == CC_SPACE) return;
		case (lex_mode)
			LX_NAME: begin
				if (cls == CC_LETTER) begin
					settled = 1'b1;
				end else begin
					has_flush  = 1'b1;
					flush_kind = mtl_pkg::TK_NAME;
					lex_mode   = LX_IDLE;
				end
			end
			LX_QUOTE: begin
				if (cls == CC_LETTER || cls == CC_DIGIT) begin
					settled = 1'b1;
				end else begin
					// closing quote ends the value, anything else cuts it off
					has_flush = 1'b1;
					lex_mode  = LX_IDLE;
					if (cls == CC_QUOTE) begin
						flush_kind = mtl_pkg::TK_VALUE;
						settled    = 1'b1;
					end else begin
						flush_kind = mtl_pkg::TK_UNKNOWN;
					end
				end
			end
			default: lex_mode = LX_IDLE;
		endcase
		if (!settled) begin
			has_sym = 1'b1;
			case (cls)
				CC_OPEN:  sym_kind = mtl_pkg::TK_START;
				CC_SLASH: sym_kind = mtl_pkg::TK_SLASH;
				CC_CLOSE: sym_kind = mtl_pkg::TK_CLOSE;
				CC_EQUAL: sym_kind = mtl_pkg::TK_EQUAL;
				CC_LETTER: begin
					has_sym  = 1'b0;
					lex_mode = LX_NAME;
				end
				CC_QUOTE: begin
					has_sym  = 1'b0;
					lex_mode = LX_QUOTE;
				end
				default: begin
					// digit or stray byte from idle: error, then dead until reset
					sym_kind = mtl_pkg::TK_UNKNOWN;
					sym_err  = 1'b1;
					halted   = 1'b1;
				end
			endcase
		end
		rec.err  = 1'b0;
		rec.line = line_cnt;
		rec.col  = col_cnt;
		if (has_flush) begin
			rec.kind = flush_kind;
			rec.last = !has_sym;
			due_tokens.insert(due_tokens.size(), rec);
		end
		if (has_sym) begin
			rec.kind = sym_kind;
			rec.err  = sym_err;
			rec.last = 1'b1;
			due_tokens.insert(due_tokens.size(), rec);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_mode       = LX_IDLE;
			line_cnt       = '0;
			col_cnt        = '0;
			halted         = 1'b0;
			leftovers_done = 1'b0;
			due_tokens.delete();
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready) lex_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				n_tokens++;
				if (due_tokens.size() == 0) begin
					report_mismatch($sformatf("item %0d with none due: kind %0d line %0d col %0d",
						n_tokens, m_tuser[2:0], m_tdata[15:0], m_tdata[31:16]));
				end else begin
					want = due_tokens.pop_front();
					if (m_tuser[2:0] !== want.kind)
						report_mismatch($sformatf("item %0d kind %0d, want %0d",
							n_tokens, m_tuser[2:0], want.kind));
					if (m_tuser[3] !== want.err)
						report_mismatch($sformatf("item %0d error %0b, want %0b",
							n_tokens, m_tuser[3], want.err));
					if (m_tdata[15:0] !== want.line)
						report_mismatch($sformatf("item %0d line %0d, want %0d",
							n_tokens, m_tdata[15:0], want.line));
					if (m_tdata[31:16] !== want.col)
						report_mismatch($sformatf("item %0d column %0d, want %0d",
							n_tokens, m_tdata[31:16], want.col));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("item %0d last %0b, want %0b",
							n_tokens, m_tlast, want.last));
				end
			end
			if (run_done && !leftovers_done) begin
				leftovers_done = 1'b1;
				while (due_tokens.size() != 0) begin
					want = due_tokens.pop_front();
					report_mismatch($sformatf("token never seen: kind %0d line %0d col %0d",
						want.kind, want.line, want.col));
				end
			end
			pending <= due_tokens.size();
		end
	end

endmodule

// File: tb/markup_token_lexer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// markup_token_lexer_unit_test
// feeds the lexer directed and random markup text under varying back-pressure,
// ends with an illegal byte followed by swallowed bytes and checks the tokens
// ----------------------------------------------------------------------------

module markup_token_lexer_unit_test;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int RUN_LIMIT_NS = 10_000_000;

	typedef enum int {
		ILL_DIGIT,
		ILL_BYTE,
		ILL_AFTER_NAME,
		ILL_IN_VALUE
	} illegal_case_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;     // [7:0] char_in
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;             // [15:0] line_no, [31:16] column_no
	logic [3:0]  m_tuser;             // [2:0] token_kind, [3] error
	logic        m_tlast;

	logic        rx_hold_req = 1'b0;
	logic        run_done = 1'b0;
	int          rx_hold_left = 0;
	int          rx_idle_pct = 0;
	int          tx_idle_pct = 0;
	int          sent_bytes = 0;
	int          pending;
	int          fail_count;
	int          token_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	markup_token_lexer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	mtl_token_checker lex_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.run_done    (run_done),
		.pending     (pending),
		.fail_count  (fail_count),
		.token_count (token_count)
	);

	// receiver: random stalls, or a long hold-off once asked for
	always @(posedge clk) begin
		if (rx_hold_req) begin
			rx_hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic logic [7:0] random_letter();
		int r;
		r = $urandom_range(53);
		if (r < 26) return "a" + r[7:0];
		if (r < 52) return "A" + r[7:0] - 8'd26;
		if (r == 52) return "_";
		return ".";
	endfunction

	function automatic logic [7:0] random_digit();
		int r;
		r = $urandom_range(9);
		return "0" + r[7:0];
	endfunction

	function automatic logic [7:0] random_blank();
		case ($urandom_range(3))
			0: return " ";
			1: return "\t";
			2: return "\r";
			default: return "\n";
		endcase
	endfunction

	// symbols that end a name or cut off a value
	function automatic logic [7:0] random_cutter();
		case ($urandom_range(3))
			0: return "<";
			1: return ">";
			2: return "/";
			default: return "=";
		endcase
	endfunction

	function automatic logic [7:0] random_unknown();
		int r;
		case ($urandom_range(3))
			0: begin
				r = $urandom_range(128, 255);
				return r[7:0];
			end
			1: begin
				// control codes below tab
				r = $urandom_range(8);
				return r[7:0];
			end
			2: return "#";
			default: return "~";
		endcase
	endfunction

	task automatic put_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		sent_bytes++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endtask

	task automatic maybe_blank();
		if ($urandom_range(99) < 12) put_byte(random_blank());
	endtask

	task automatic send_name();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) begin
			put_byte(random_letter());
			maybe_blank();
		end
	endtask

	task automatic send_tag();
		int n_attr;
		int n_val;
		put_byte("<");
		maybe_blank();
		if ($urandom_range(4) == 0) put_byte("/");
		send_name();
		n_attr = $urandom_range(0, 3);
		repeat (n_attr) begin
			put_byte(" ");
			send_name();
			maybe_blank();
			put_byte("=");
			maybe_blank();
			put_byte("\"");
			n_val = $urandom_range(0, 6);
			repeat (n_val) begin
				put_byte(($urandom_range(1) != 0) ? random_letter() : random_digit());
				maybe_blank();
			end
			put_byte("\"");
		end
		maybe_blank();
		if ($urandom_range(4) == 0) put_byte("/");
		put_byte(">");
	endtask

	// mostly well-formed tags; quotes only ever come in closed pairs or are
	// cut off by a symbol, so no digit lands outside a value
	task automatic send_random(input int quota);
		int start;
		int n;
		start = sent_bytes;
		while (sent_bytes - start < quota) begin
			case ($urandom_range(9))
				0: begin
					n = $urandom_range(1, 4);
					repeat (n) begin
						case ($urandom_range(5))
							0, 1: put_byte(random_cutter());
							2, 3: put_byte(random_letter());
							default: put_byte(random_blank());
						endcase
					end
				end
				1: begin
					// value cut off by a symbol, flushed as unknown
					put_byte("\"");
					n = $urandom_range(0, 4);
					repeat (n) put_byte(($urandom_range(1) != 0) ? random_letter() : random_digit());
					put_byte(random_cutter());
				end
				2: begin
					send_name();
					maybe_blank();
				end
				default: send_tag();
			endcase
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		illegal_case_t fault;
		int            waited;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles a little, receiver a lot
		tx_idle_pct = 10;
		rx_idle_pct <= 59;
		// name cut by equal, blanks inside a name, digits and a newline in a value
		send_text("<Az_.\t=\"09\r\n9a\">");
		// name cut by a quote, value cut by close, name cut by open
		send_text("/q\"z>b<");
		wait_drained();

		// long receiver hold-off while bytes keep coming
		rx_hold_req <= 1'b1;
		@(posedge clk);
		rx_hold_req <= 1'b0;
		send_random(270);
		wait_drained();

		tx_idle_pct = 59;
		rx_idle_pct <= 10;
		send_random(270);
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		send_random(260);

		// a digit value, then a name left pending for the close below
		send_text("<a=\"1\">");
		send_text("<b/>c");
		wait_drained();

		// one illegal byte halts the lexer; later bytes are swallowed
		tx_idle_pct = 10;
		rx_idle_pct <= 30;
		put_byte(">");
		fault = illegal_case_t'($urandom_range(3));
		case (fault)
			ILL_DIGIT: put_byte(random_digit());
			ILL_BYTE: put_byte(random_unknown());
			ILL_AFTER_NAME: begin
				put_byte(random_letter());
				put_byte(random_unknown());
			end
			default: begin
				put_byte("\"");
				put_byte(random_digit());
				put_byte(random_unknown());
			end
		endcase
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'h80);
		put_byte("<");
		repeat (20) put_byte(8'($urandom_range(255)));
		s_tvalid <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		run_done <= 1'b1;
		repeat (3) @(posedge clk);

		$display("lexer run: %0d bytes offered, %0d token items checked",
			sent_bytes, token_count);
		$display("tags, names, values, cut-off runs, long stalls, halt on a bad byte");
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("run limit reached with %0d tokens outstanding", pending);
		$display("FAIL");
		$finish;
	end

endmodule
